FILE: rtl/nvp_pkg.sv
// nvp_pkg: shared widths, codes and the command type of the nearest vertex picker
// no dependencies; used by the interfaces and every module of the block
package nvp_pkg;

  // table size default
  localparam int unsigned MAX_VERTICES_DEF = 1024;

  // payload widths
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned INDEX_W    = 10;
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned HL_W       = 10;
  localparam int unsigned DIST_W     = 33;
  localparam int unsigned SQ_W       = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  // command queue depth, a power of two
  localparam int unsigned QUEUE_DEPTH = 2;

  // item modes
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CYCLE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_ENABLE = 2'd1;

  // classified operation handed to the back end
  typedef enum logic [1:0] {
    CMD_NOP   = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_CYCLE = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                      op;
    logic [INDEX_W-1:0]        index;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      depends;
    logic [COUNT_W-1:0]        n;
  } cmd_t;

endpackage

FILE: rtl/nvp_if.sv
// nvp_if: valid/ready channel interfaces for items, results and config writes
// depends on nvp_pkg for payload widths
interface nvp_item_if;
  logic                              valid;
  logic                              ready;
  logic [nvp_pkg::MODE_W-1:0]        mode;
  logic [nvp_pkg::INDEX_W-1:0]       entry_index;
  logic signed [nvp_pkg::COORD_W-1:0] point_x;
  logic signed [nvp_pkg::COORD_W-1:0] point_y;
  logic                              entry_depends;

  modport source (output valid, mode, entry_index, point_x, point_y, entry_depends,
                  input ready);
  modport sink (input valid, mode, entry_index, point_x, point_y, entry_depends,
                output ready);
endinterface

interface nvp_result_if;
  logic                        valid;
  logic                        ready;
  logic [nvp_pkg::HL_W-1:0]    highlight_index;
  logic [nvp_pkg::DIST_W-1:0]  squared_distance;
  logic                        found;

  modport source (output valid, highlight_index, squared_distance, found, input ready);
  modport sink (input valid, highlight_index, squared_distance, found, output ready);
endinterface

interface nvp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [nvp_pkg::CFG_IDX_W-1:0]   index;
  logic [nvp_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/nearest_vertex_picker.sv
// Nearest vertex picker. Keeps a table of screen vertices and a highlight index. A load
// item's result is registered: the item passes through the command queue, then the result
// register. A query scans entries 0 to n-1 (n = vertex_count, capped at the table size) for
// the least squared distance. A cycle item reads the highlighted entry, then walks forward
// with wraparound and stops early when a coincident entry turns up. The scan rate is one
// entry per cycle, set by the single read port of the vertex memory. A two-entry command
// queue lets new items be taken while a scan runs; a result waiting in the result register
// holds off the next command, which starts the cycle after that result is taken. Table
// entries are undefined until loaded; there is no clearing pass after reset. Config writes
// must be made while the block is idle.
// depends on nvp_pkg, nvp_if, nvp_front, nvp_fifo and nvp_back
module nearest_vertex_picker #(
  parameter int unsigned MAX_VERTICES = nvp_pkg::MAX_VERTICES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  nvp_cfg_if.sink      cfg_i,
  nvp_item_if.sink     item_i,
  nvp_result_if.source result_o
);

  logic          push;
  logic          full;
  logic          pop;
  logic          empty;
  nvp_pkg::cmd_t cmd_in;
  nvp_pkg::cmd_t cmd_out;

  // intake and classification
  nvp_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .item_i (item_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (cmd_in)
  );

  // command queue
  nvp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (cmd_out),
    .empty_o (empty)
  );

  // memory, scan and result
  nvp_back #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .cmd_i    (cmd_out),
    .pop_o    (pop),
    .result_o (result_o)
  );

endmodule

FILE: rtl/nvp_front.sv
// nvp_front: config registers, item intake and classification into commands
// depends on nvp_pkg and the channel interfaces in nvp_if
module nvp_front #(
  parameter int unsigned MAX_VERTICES = nvp_pkg::MAX_VERTICES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  nvp_cfg_if.sink          cfg_i,
  nvp_item_if.sink         item_i,
  input  logic             full_i,
  output logic             push_o,
  output nvp_pkg::cmd_t    cmd_o
);

  logic [nvp_pkg::COUNT_W-1:0] count_q;
  logic                        cyc_en_q;
  logic [nvp_pkg::COUNT_W-1:0] n_use;

  // config writes are always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      cyc_en_q <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        nvp_pkg::CFG_VERTEX_COUNT: count_q  <= cfg_i.data;
        nvp_pkg::CFG_CYCLE_ENABLE: cyc_en_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // entries in use saturate at the table size
  assign n_use = (32'(count_q) > 32'(MAX_VERTICES)) ?
                 nvp_pkg::COUNT_W'(MAX_VERTICES) : count_q;

  // item beat handshake
  assign item_i.ready = !full_i;
  assign push_o       = item_i.valid && !full_i;

  // classify the item; anything with nothing to do becomes a no-op
  always_comb begin
    cmd_o.index   = item_i.entry_index;
    cmd_o.x       = item_i.point_x;
    cmd_o.y       = item_i.point_y;
    cmd_o.depends = item_i.entry_depends;
    cmd_o.n       = n_use;
    unique case (item_i.mode)
      nvp_pkg::MODE_LOAD:
        cmd_o.op = (32'(item_i.entry_index) < 32'(MAX_VERTICES)) ?
                   nvp_pkg::CMD_LOAD : nvp_pkg::CMD_NOP;
      nvp_pkg::MODE_QUERY:
        cmd_o.op = (n_use != '0) ? nvp_pkg::CMD_QUERY : nvp_pkg::CMD_NOP;
      nvp_pkg::MODE_CYCLE:
        cmd_o.op = (cyc_en_q && n_use != '0) ? nvp_pkg::CMD_CYCLE : nvp_pkg::CMD_NOP;
      default:
        cmd_o.op = nvp_pkg::CMD_NOP;
    endcase
  end

endmodule

FILE: rtl/nvp_fifo.sv
// nvp_fifo: short command queue between the front end and the back end
// depends on nvp_pkg for the command type and depth
module nvp_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  nvp_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output nvp_pkg::cmd_t cmd_o,
  output logic          empty_o
);

  localparam int unsigned PW = (nvp_pkg::QUEUE_DEPTH > 1) ? $clog2(nvp_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(nvp_pkg::QUEUE_DEPTH + 1);

  nvp_pkg::cmd_t  slot_q [nvp_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_q;
  logic [PW-1:0]  rd_ptr_q;
  logic [CW-1:0]  count_q;

  assign full_o  = (32'(count_q) == 32'(nvp_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign cmd_o   = slot_q[rd_ptr_q];

  // slot storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && full_o |-> pop_i)
    else $error("command queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("command queue read while empty");
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(nvp_pkg::QUEUE_DEPTH))
    else $error("command queue fill level out of range");
`endif

endmodule

FILE: rtl/nvp_back.sv
// nvp_back: vertex memory, scan sequencer, distance pipeline and result register
// depends on nvp_pkg and the result interface in nvp_if
module nvp_back #(
  parameter int unsigned MAX_VERTICES = nvp_pkg::MAX_VERTICES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  nvp_pkg::cmd_t cmd_i,
  output logic          pop_o,
  nvp_result_if.source  result_o
);

  localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CW = nvp_pkg::COORD_W;
  localparam int unsigned DW = 2 * CW + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_REF   = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;

  // vertex memory, {depends, y, x}
  logic [DW-1:0] mem_q [MAX_VERTICES];
  logic [DW-1:0] rdata_q;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  logic [2:0]                  state_q, state_d;
  nvp_pkg::cmd_e               op_q;
  logic signed [CW-1:0]        px_q, py_q;
  logic [nvp_pkg::COUNT_W-1:0] n_q;
  logic [nvp_pkg::COUNT_W-1:0] remain_q;
  logic [AW-1:0]               cur_q, cur_next, hl_next;
  logic [AW-1:0]               hl_q, hl_d;
  logic signed [CW-1:0]        ref_x_q, ref_y_q;
  logic                        issue;
  logic                        hit_q, cyc_hit;

  // scan pipeline
  logic                        v1_q, v2_q, v3_q;
  logic [AW-1:0]               a1_q, a2_q, a3_q;
  logic signed [CW:0]          dx_q, dy_q;
  logic signed [2*CW+1:0]      sqx_full, sqy_full;
  logic [nvp_pkg::SQ_W-1:0]    sqx_q, sqy_q;
  logic [nvp_pkg::DIST_W-1:0]  dsum;
  logic [nvp_pkg::DIST_W-1:0]  best_d_q;
  logic [AW-1:0]               best_idx_q;
  logic signed [CW-1:0]        rx, ry;
  logic                        rdep;
  logic                        pipe_empty;

  // result register
  logic                        out_valid_q;
  logic [nvp_pkg::HL_W-1:0]    out_hl_q;
  logic [nvp_pkg::DIST_W-1:0]  out_dist_q;
  logic                        out_found_q;
  logic                        res_load;
  logic [nvp_pkg::DIST_W-1:0]  res_dist;
  logic                        res_found;
  logic                        cyc_ok;

  assign rx   = signed'(rdata_q[CW-1:0]);
  assign ry   = signed'(rdata_q[2*CW-1:CW]);
  assign rdep = rdata_q[DW-1];

  assign pop_o      = (state_q == ST_IDLE) && !empty_i && !out_valid_q;
  assign cyc_ok     = 32'(hl_q) < 32'(cmd_i.n);
  assign pipe_empty = !v1_q && !v2_q && !v3_q;
  assign issue      = (state_q == ST_SCAN) && (remain_q != '0) && !hit_q;

  // forward walk with wraparound over the entries in use
  assign cur_next = (32'(cur_q) + 32'd1 >= 32'(n_q)) ? '0 : cur_q + 1'b1;
  assign hl_next  = (32'(hl_q) + 32'd1 >= 32'(n_q)) ? '0 : hl_q + 1'b1;

  // memory port control
  always_comb begin
    wr_en   = pop_o && (cmd_i.op == nvp_pkg::CMD_LOAD);
    wr_addr = AW'(cmd_i.index);
    rd_en   = 1'b0;
    rd_addr = cur_q;
    if (pop_o && cmd_i.op == nvp_pkg::CMD_CYCLE) begin
      rd_en   = 1'b1;
      rd_addr = hl_q;
    end else if (issue) begin
      rd_en   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= {cmd_i.depends, cmd_i.y, cmd_i.x};
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // coincident entry check on each scanned beat
  assign cyc_hit = v1_q && (op_q == nvp_pkg::CMD_CYCLE) && !hit_q &&
                   (rx == ref_x_q) && (ry == ref_y_q) && !rdep;

  // squares and their sum
  assign sqx_full = dx_q * dx_q;
  assign sqy_full = dy_q * dy_q;
  assign dsum     = {1'b0, sqx_q} + {1'b0, sqy_q};

  // sequencer and result selection
  always_comb begin
    state_d   = state_q;
    res_load  = 1'b0;
    hl_d      = hl_q;
    res_dist  = '0;
    res_found = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          priority if (cmd_i.op == nvp_pkg::CMD_QUERY) begin
            state_d = ST_SCAN;
          end else if (cmd_i.op == nvp_pkg::CMD_CYCLE && cyc_ok) begin
            state_d = ST_REF;
          end else begin
            res_load = 1'b1;
          end
        end
      end
      ST_REF: state_d = ST_SCAN;
      ST_SCAN: begin
        if (remain_q == '0 || hit_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_d  = ST_IDLE;
          res_load = 1'b1;
          if (op_q == nvp_pkg::CMD_QUERY) begin
            hl_d      = best_idx_q;
            res_dist  = best_d_q;
            res_found = 1'b1;
          end else if (hit_q) begin
            hl_d      = best_idx_q;
            res_found = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hl_q        <= '0;
      hit_q       <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      hl_q    <= hl_d;
      v1_q    <= issue;
      v2_q    <= v1_q && (op_q == nvp_pkg::CMD_QUERY);
      v3_q    <= v2_q;
      if (pop_o) begin
        hit_q <= 1'b0;
      end else if (cyc_hit) begin
        hit_q <= 1'b1;
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // operands, walk position, pipeline data and running best
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      op_q       <= cmd_i.op;
      px_q       <= cmd_i.x;
      py_q       <= cmd_i.y;
      n_q        <= cmd_i.n;
      remain_q   <= cmd_i.n;
      cur_q      <= '0;
      best_d_q   <= '1;
      best_idx_q <= '0;
    end else if (state_q == ST_REF) begin
      ref_x_q  <= rx;
      ref_y_q  <= ry;
      cur_q    <= hl_next;
      remain_q <= n_q - 1'b1;
    end else if (issue) begin
      cur_q    <= cur_next;
      remain_q <= remain_q - 1'b1;
    end
    if (issue) begin
      a1_q <= cur_q;
    end
    if (v1_q) begin
      dx_q <= {px_q[CW-1], px_q} - {rx[CW-1], rx};
      dy_q <= {py_q[CW-1], py_q} - {ry[CW-1], ry};
      a2_q <= a1_q;
    end
    if (v2_q) begin
      sqx_q <= sqx_full[nvp_pkg::SQ_W-1:0];
      sqy_q <= sqy_full[nvp_pkg::SQ_W-1:0];
      a3_q  <= a2_q;
    end
    if (!pop_o && v3_q && dsum < best_d_q) begin
      best_d_q   <= dsum;
      best_idx_q <= a3_q;
    end
    if (!pop_o && cyc_hit) begin
      best_idx_q <= a1_q;
    end
    if (res_load) begin
      out_hl_q    <= nvp_pkg::HL_W'(hl_d);
      out_dist_q  <= res_dist;
      out_found_q <= res_found;
    end
  end

  // result beat
  assign result_o.valid            = out_valid_q;
  assign result_o.highlight_index  = out_hl_q;
  assign result_o.squared_distance = out_dist_q;
  assign result_o.found            = out_found_q;

`ifndef SYNTHESIS
  a_result_into_free_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> !out_valid_q)
    else $error("result register overwritten before it was taken");
  a_pipe_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> $past(v1_q, 2))
    else $error("distance pipeline beat without a memory read");
  a_hit_only_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q |-> (op_q == nvp_pkg::CMD_CYCLE))
    else $error("coincident hit recorded outside a cycle operation");
  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> pipe_empty)
    else $error("scan pipeline still busy in idle");
`endif

endmodule

FILE: sim/nearest_vertex_picker_tb.sv
// nearest_vertex_picker_tb: self-checking bench for the nearest vertex picker
// runs directed and random load, query and cycle items and checks every result
// depends on nvp_pkg, nvp_if and nearest_vertex_picker from the rtl folder
module nearest_vertex_picker_tb;

  localparam int unsigned TABLE_SIZE      = nvp_pkg::MAX_VERTICES_DEF;
  localparam int unsigned ITEMS_PER_BLOCK = 27;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned POOL_SIZE       = 8;

  // mode 3 has no meaning in the block and must act as a no-op
  localparam logic [nvp_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic [nvp_pkg::MODE_W-1:0]         mode;
    logic [nvp_pkg::INDEX_W-1:0]        index;
    logic signed [nvp_pkg::COORD_W-1:0] x;
    logic signed [nvp_pkg::COORD_W-1:0] y;
    logic                               depends;
  } vertex_item_t;

  typedef struct {
    logic [nvp_pkg::HL_W-1:0]   highlight;
    logic [nvp_pkg::DIST_W-1:0] distance;
    logic                       found;
  } pick_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  nvp_cfg_if    cfg_bus ();
  nvp_item_if   item_bus ();
  nvp_result_if result_bus ();

  nearest_vertex_picker dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_bus),
    .item_i   (item_bus),
    .result_o (result_bus)
  );

  // vertex table and registers as the block should hold them
  logic signed [nvp_pkg::COORD_W-1:0] tbl_x [TABLE_SIZE];
  logic signed [nvp_pkg::COORD_W-1:0] tbl_y [TABLE_SIZE];
  logic                               tbl_dep [TABLE_SIZE];
  logic [nvp_pkg::HL_W-1:0]           hl_now;
  logic [nvp_pkg::COUNT_W-1:0]        cfg_count;
  logic                               cfg_cycle;

  // stimulus bookkeeping: which entries have been loaded so far
  bit                                 loaded [TABLE_SIZE];
  int unsigned                        loaded_prefix;
  logic signed [nvp_pkg::COORD_W-1:0] pool_x [POOL_SIZE];
  logic signed [nvp_pkg::COORD_W-1:0] pool_y [POOL_SIZE];

  vertex_item_t pending_items [$];
  pick_t        expected_picks [$];
  vertex_item_t cur_item;
  bit           item_taken;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;
  int unsigned  hold_left;
  int unsigned  mismatch_count;
  int unsigned  sat_hl;

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  function automatic longint sq_dist(input logic signed [nvp_pkg::COORD_W-1:0] px,
                                     input logic signed [nvp_pkg::COORD_W-1:0] py,
                                     input int unsigned i);
    longint dx;
    longint dy;
    dx = longint'(px) - longint'(tbl_x[i]);
    dy = longint'(py) - longint'(tbl_y[i]);
    return dx * dx + dy * dy;
  endfunction

  // next highlight, distance and found flag for one item, updating the table
  function automatic pick_t predict_pick(input vertex_item_t it);
    pick_t       res;
    int unsigned n;
    int unsigned h;
    int unsigned i;
    int unsigned best;
    longint      d;
    longint      best_d;
    res.distance = '0;
    res.found    = 1'b0;
    n = (32'(cfg_count) > TABLE_SIZE) ? TABLE_SIZE : 32'(cfg_count);
    case (it.mode)
      nvp_pkg::MODE_LOAD: begin
        tbl_x[it.index]   = it.x;
        tbl_y[it.index]   = it.y;
        tbl_dep[it.index] = it.depends;
      end
      nvp_pkg::MODE_QUERY: begin
        if (n > 0) begin
          best   = 0;
          best_d = sq_dist(it.x, it.y, 0);
          for (i = 1; i < n; i++) begin
            d = sq_dist(it.x, it.y, i);
            // strict compare keeps the lowest index on a tie
            if (d < best_d) begin
              best_d = d;
              best   = i;
            end
          end
          hl_now       = nvp_pkg::HL_W'(best);
          res.distance = nvp_pkg::DIST_W'(best_d);
          res.found    = 1'b1;
        end
      end
      nvp_pkg::MODE_CYCLE: begin
        h = 32'(hl_now);
        if (cfg_cycle && n > 0 && h < n) begin
          i = h;
          for (int k = 1; k < n; k++) begin
            i = (i + 1 >= n) ? 0 : i + 1;
            if (tbl_x[i] == tbl_x[h] && tbl_y[i] == tbl_y[h] && !tbl_dep[i]) begin
              hl_now    = nvp_pkg::HL_W'(i);
              res.found = 1'b1;
              break;
            end
          end
        end
      end
      default: ;
    endcase
    res.highlight = hl_now;
    return res;
  endfunction

  function automatic logic signed [nvp_pkg::COORD_W-1:0] rand_coord();
    case ($urandom_range(9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      default: return nvp_pkg::COORD_W'($urandom);
    endcase
  endfunction

  function automatic void queue_item(input logic [nvp_pkg::MODE_W-1:0] mode,
                                     input int unsigned idx,
                                     input logic signed [nvp_pkg::COORD_W-1:0] x,
                                     input logic signed [nvp_pkg::COORD_W-1:0] y,
                                     input logic dep);
    vertex_item_t it;
    it.mode    = mode;
    it.index   = nvp_pkg::INDEX_W'(idx);
    it.x       = x;
    it.y       = y;
    it.depends = dep;
    pending_items.push_back(it);
    if (mode == nvp_pkg::MODE_LOAD) begin
      loaded[it.index] = 1'b1;
      while (loaded_prefix < TABLE_SIZE && loaded[loaded_prefix]) loaded_prefix++;
    end
  endfunction

  // count for the next block; never reaches past the loaded prefix
  function automatic int unsigned pick_count();
    int unsigned lim;
    int unsigned r;
    lim = (loaded_prefix < 48) ? loaded_prefix : 48;
    r   = $urandom_range(99);
    if (lim == 0 || r < 8) return 0;
    if (r < 16) return 1;
    if (r < 26 && loaded_prefix <= 64) return loaded_prefix;
    return $urandom_range(lim, 1);
  endfunction

  // random mix: loads grow the table and mostly reuse pool points, queries land on or near them,
  // so that coincident vertices exist for the cycle items to walk
  task automatic plan_block(input int unsigned num);
    int unsigned                        r;
    int unsigned                        p;
    int unsigned                        idx;
    logic signed [nvp_pkg::COORD_W-1:0] qx;
    logic signed [nvp_pkg::COORD_W-1:0] qy;
    for (int j = 0; j < num; j++) begin
      r = $urandom_range(99);
      p = $urandom_range(POOL_SIZE - 1);
      if (r < 35) begin
        case ($urandom_range(9))
          0, 1:    idx = $urandom_range(TABLE_SIZE - 1);
          2, 3, 4: idx = $urandom_range(loaded_prefix < TABLE_SIZE ? loaded_prefix : 0);
          default: idx = (loaded_prefix < TABLE_SIZE) ? loaded_prefix
                                                      : $urandom_range(TABLE_SIZE - 1);
        endcase
        if ($urandom_range(99) < 60) begin
          qx = pool_x[p];
          qy = pool_y[p];
        end else begin
          qx = rand_coord();
          qy = rand_coord();
        end
        queue_item(nvp_pkg::MODE_LOAD, idx, qx, qy, $urandom_range(99) < 30);
      end else if (r < 70) begin
        case ($urandom_range(3))
          0, 1: begin
            qx = pool_x[p];
            qy = pool_y[p];
          end
          2: begin
            qx = nvp_pkg::COORD_W'(int'(pool_x[p]) + int'($urandom_range(6)) - 3);
            qy = nvp_pkg::COORD_W'(int'(pool_y[p]) + int'($urandom_range(6)) - 3);
          end
          default: begin
            qx = rand_coord();
            qy = rand_coord();
          end
        endcase
        queue_item(nvp_pkg::MODE_QUERY, $urandom_range(TABLE_SIZE - 1), qx, qy,
                   1'($urandom_range(1)));
      end else if (r < 95) begin
        queue_item(nvp_pkg::MODE_CYCLE, $urandom_range(TABLE_SIZE - 1), rand_coord(),
                   rand_coord(), 1'($urandom_range(1)));
      end else begin
        queue_item(MODE_UNUSED, $urandom_range(TABLE_SIZE - 1), rand_coord(), rand_coord(),
                   1'($urandom_range(1)));
      end
    end
  endtask

  task automatic write_reg(input logic [nvp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [nvp_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = value;
    @(posedge clk_i);
    while (cfg_bus.ready !== 1'b1) @(posedge clk_i);
    if (idx == nvp_pkg::CFG_VERTEX_COUNT) cfg_count = value[nvp_pkg::COUNT_W-1:0];
    else if (idx == nvp_pkg::CFG_CYCLE_ENABLE) cfg_cycle = value[0];
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic set_regs(input int unsigned count, input bit enable);
    write_reg(nvp_pkg::CFG_VERTEX_COUNT, nvp_pkg::CFG_DATA_W'(count));
    write_reg(nvp_pkg::CFG_CYCLE_ENABLE, nvp_pkg::CFG_DATA_W'(enable));
  endtask

  // wait until every queued item went in and every result came back
  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_items.size() != 0 || item_bus.valid === 1'b1 ||
           expected_picks.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // item driver: hold a beat until taken, idle at random between beats
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      item_bus.valid = 1'b0;
    end else if (!item_bus.valid || item_taken) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_item               = pending_items.pop_front();
        item_bus.mode          = cur_item.mode;
        item_bus.entry_index   = cur_item.index;
        item_bus.point_x       = cur_item.x;
        item_bus.point_y       = cur_item.y;
        item_bus.entry_depends = cur_item.depends;
        item_bus.valid         = 1'b1;
      end else begin
        item_bus.valid = 1'b0;
      end
    end
  end

  // accepted item beat: predict its result
  always @(posedge clk_i) begin
    item_taken = rst_ni && item_bus.valid && item_bus.ready;
    if (item_taken) expected_picks.push_back(predict_pick(cur_item));
  end

  // long receiver hold-off, counted down here
  always @(negedge clk_i) begin
    if (hold_left > 0) hold_left--;
  end

  // result ready with random stalls
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      result_bus.ready = 1'b0;
    end else begin
      result_bus.ready = (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result monitor: compare each beat with the oldest prediction
  always @(posedge clk_i) begin : result_check
    pick_t want;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      if (expected_picks.size() == 0) begin
        report_mismatch($sformatf("result with none pending: hl %0d dist %0d found %0b",
                                  result_bus.highlight_index, result_bus.squared_distance,
                                  result_bus.found));
      end else begin
        want = expected_picks.pop_front();
        if (result_bus.highlight_index !== want.highlight)
          report_mismatch($sformatf("highlight_index got %0d want %0d",
                                    result_bus.highlight_index, want.highlight));
        if (result_bus.squared_distance !== want.distance)
          report_mismatch($sformatf("squared_distance got %0d want %0d",
                                    result_bus.squared_distance, want.distance));
        if (result_bus.found !== want.found)
          report_mismatch($sformatf("found got %0b want %0b", result_bus.found, want.found));
      end
    end
  end

  // run limit
  initial begin
    #40000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // stimulus sequence
  initial begin
    rst_ni                 = 1'b0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.index          = '0;
    cfg_bus.data           = '0;
    item_bus.valid         = 1'b0;
    item_bus.mode          = '0;
    item_bus.entry_index   = '0;
    item_bus.point_x       = '0;
    item_bus.point_y       = '0;
    item_bus.entry_depends = 1'b0;
    result_bus.ready       = 1'b0;
    hl_now                 = '0;
    cfg_count              = '0;
    cfg_cycle              = 1'b0;
    loaded_prefix          = 0;
    hold_left              = 0;
    mismatch_count         = 0;
    sat_hl                 = 0;
    send_idle_pct          = 33;
    recv_idle_pct          = 47;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      tbl_x[i]   = '0;
      tbl_y[i]   = '0;
      tbl_dep[i] = 1'b0;
      loaded[i]  = 1'b0;
    end
    for (int p = 0; p < POOL_SIZE; p++) begin
      pool_x[p] = rand_coord();
      pool_y[p] = rand_coord();
    end
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // empty table after reset, unused mode, then the directed entries
    queue_item(nvp_pkg::MODE_QUERY, 0, 5, 5, 1'b0);
    queue_item(nvp_pkg::MODE_CYCLE, 0, 0, 0, 1'b0);
    queue_item(MODE_UNUSED, TABLE_SIZE - 1, -1, 1, 1'b1);
    queue_item(nvp_pkg::MODE_LOAD, 0, -32768, -32768, 1'b0);
    queue_item(nvp_pkg::MODE_LOAD, 1, 32767, 32767, 1'b0);
    queue_item(nvp_pkg::MODE_LOAD, 2, 100, 200, 1'b0);
    queue_item(nvp_pkg::MODE_LOAD, 3, 100, 200, 1'b1);
    queue_item(nvp_pkg::MODE_LOAD, 4, 100, 200, 1'b0);
    queue_item(nvp_pkg::MODE_LOAD, 5, -32768, 32767, 1'b1);
    queue_item(nvp_pkg::MODE_LOAD, TABLE_SIZE - 1, 1, -1, 1'b1);
    wait_idle();

    // single entry: largest distance, cycle has nowhere to go
    set_regs(1, 1'b1);
    queue_item(nvp_pkg::MODE_QUERY, 0, 32767, 32767, 1'b0);
    queue_item(nvp_pkg::MODE_CYCLE, 0, 0, 0, 1'b0);
    wait_idle();

    // tie keeps the lowest index; cycling disabled
    set_regs(6, 1'b0);
    queue_item(nvp_pkg::MODE_QUERY, 0, 100, 200, 1'b0);
    queue_item(nvp_pkg::MODE_CYCLE, 0, 0, 0, 1'b0);
    wait_idle();

    // cycle skips the dependent twin, wraps around, then finds no twin
    write_reg(nvp_pkg::CFG_CYCLE_ENABLE, 1);
    queue_item(nvp_pkg::MODE_CYCLE, 0, 0, 0, 1'b0);
    queue_item(nvp_pkg::MODE_CYCLE, 0, 0, 0, 1'b0);
    queue_item(nvp_pkg::MODE_QUERY, 0, -32768, 32767, 1'b0);
    queue_item(nvp_pkg::MODE_CYCLE, 0, 0, 0, 1'b0);
    wait_idle();

    // highlight left outside the entries in use
    write_reg(nvp_pkg::CFG_VERTEX_COUNT, 2);
    queue_item(nvp_pkg::MODE_CYCLE, 0, 0, 0, 1'b0);
    queue_item(MODE_UNUSED, 0, 0, 0, 1'b0);
    wait_idle();

    // random blocks under three idle patterns
    for (int seg = 0; seg < 3; seg++) begin
      send_idle_pct = (seg == 0) ? 33 : (seg == 1) ? 47 : 0;
      recv_idle_pct = (seg == 0) ? 47 : (seg == 1) ? 33 : 0;
      for (int b = 0; b < 7; b++) begin
        set_regs(pick_count(), $urandom_range(99) < 80);
        if (seg == 2 && b == 0) hold_left = HOLD_CYCLES;
        plan_block(ITEMS_PER_BLOCK);
        wait_idle();
      end
    end

    // count above and at the table size: twins right after the highlight keep
    // each cycle walk on loaded entries
    sat_hl = 32'(hl_now);
    for (int unsigned k = 0; k < 3; k++) begin
      queue_item(nvp_pkg::MODE_LOAD, (sat_hl + k) % TABLE_SIZE, 7, -7, 1'b0);
    end
    wait_idle();
    set_regs(2047, 1'b1);
    queue_item(nvp_pkg::MODE_CYCLE, 0, 0, 0, 1'b0);
    queue_item(MODE_UNUSED, 0, 0, 0, 1'b0);
    wait_idle();
    set_regs(TABLE_SIZE, 1'b1);
    queue_item(nvp_pkg::MODE_CYCLE, 0, 0, 0, 1'b0);
    wait_idle();

    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0 && expected_picks.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/nvp_pkg.sv
rtl/nvp_if.sv
rtl/nvp_front.sv
rtl/nvp_fifo.sv
rtl/nvp_back.sv
rtl/nearest_vertex_picker.sv
sim/nearest_vertex_picker_tb.sv
